### src/angular_sector_bin_index_unit_macros.svh
// Assertion macros shared by the angular sector bin index RTL.
`ifndef ANGULAR_SECTOR_BIN_INDEX_UNIT_MACROS_SVH
`define ANGULAR_SECTOR_BIN_INDEX_UNIT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASBI_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASBI_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### src/asbi_pkg.sv
// Types and constants shared by the angular sector bin index modules.
`default_nettype none

package asbi_pkg;

    localparam int CORDIC_STEPS = 18;

    // Arctangent of 2^-i in turns, scaled to a 32-bit accumulator.
    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F
    };

    localparam logic [31:0] HALF_TURN = 32'h8000_0000;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_CENTRE  = 3'd0,
        REG_REF_X   = 3'd1,
        REG_REF_Y   = 3'd2,
        REG_INNER   = 3'd3,
        REG_OUTER   = 3'd4,
        REG_ANGLE   = 3'd5,
        REG_SCALE   = 3'd6,
        REG_COUNT   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [59:0] centre_point;
        logic [47:0] ref_x_vector;
        logic [47:0] ref_y_vector;
        logic [19:0] inner_radius;
        logic [19:0] outer_radius;
        logic [31:0] angle_range;
        logic [31:0] bin_scale;
        logic [8:0]  bin_count;
    } t_cfg;

    // Data handed from one CORDIC cell to the next.
    typedef struct packed {
        logic signed [48:0] re;
        logic signed [48:0] im;
        logic [31:0]        acc;
        logic               zero;
        logic               ok;
    } t_cord;

endpackage

`default_nettype wire

### src/asbi_proj.sv
// Projection front end: offset, plane projection, squared radius and quadrant fold.
`default_nettype none

module asbi_proj (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  asbi_pkg::t_cfg      i_cfg,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire signed [19:0]   i_point_x,
    input  wire signed [19:0]   i_point_y,
    input  wire signed [19:0]   i_point_z,
    output logic                o_valid,
    input  wire                 i_ready,
    output asbi_pkg::t_cord     o_cord
);

    localparam int NS = 8;

    logic [NS:1]   r_v;
    logic [NS+1:1] en;

    logic signed [15:0] vx [3];
    logic signed [15:0] vy [3];
    logic signed [19:0] ctr [3];
    logic signed [19:0] pt [3];

    logic signed [20:0] r_d [3];
    logic signed [36:0] r_pa [3];
    logic signed [36:0] r_pb [3];
    logic signed [24:0] r_a;
    logic signed [24:0] r_b;
    logic signed [40:0] r_qa [3];
    logic signed [40:0] r_qb [3];
    logic signed [27:0] r_m [3];
    logic signed [43:0] r_py [3];
    logic signed [43:0] r_px [3];
    logic signed [55:0] r_sq [3];
    logic signed [45:0] r_y;
    logic signed [45:0] r_x;
    logic [56:0]        r_r2;
    logic [39:0]        r_rin2;
    logic [39:0]        r_rout2;
    asbi_pkg::t_cord    r_cord;

    logic signed [38:0] sa;
    logic signed [38:0] sb;
    logic signed [41:0] sm [3];
    asbi_pkg::t_cord    n_cord;
    logic signed [48:0] ye;
    logic signed [48:0] xe;

    // Unpack the configuration fields.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vx[i]  = $signed(i_cfg.ref_x_vector[16*i +: 16]);
            vy[i]  = $signed(i_cfg.ref_y_vector[16*i +: 16]);
            ctr[i] = $signed(i_cfg.centre_point[20*i +: 20]);
        end
        pt[0] = i_point_x;
        pt[1] = i_point_y;
        pt[2] = i_point_z;
    end

    // A stage loads when it is empty or its successor moves.
    always_comb begin
        en[NS+1] = i_ready;
        for (int k = NS; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[1];
    assign o_valid = r_v[NS];
    assign o_cord  = r_cord;

    // Dot products reduced to Q.0 (integer), projected components and the quadrant fold.
    always_comb begin
        sa = 39'(r_pa[0]) + 39'(r_pa[1]) + 39'(r_pa[2]);
        sb = 39'(r_pb[0]) + 39'(r_pb[1]) + 39'(r_pb[2]);
        for (int i = 0; i < 3; i++) begin
            sm[i] = 42'(r_qa[i]) + 42'(r_qb[i]);
        end
        ye = 49'(r_y);
        xe = 49'(r_x);
        n_cord.zero = (r_y == '0) && (r_x == '0);
        n_cord.ok   = (r_r2 != '0) && (r_r2 >= 57'(r_rin2)) && (r_r2 <= 57'(r_rout2));
        if (r_y < 0) begin
            n_cord.re  = -ye;
            n_cord.im  = -xe;
            n_cord.acc = asbi_pkg::HALF_TURN;
        end else begin
            n_cord.re  = ye;
            n_cord.im  = xe;
            n_cord.acc = '0;
        end
    end

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 1; k <= NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= (k == 1) ? i_valid : r_v[k-1];
                end
            end
        end
    end

    // Squared radii follow the configuration.
    always_ff @(posedge i_clk) begin
        r_rin2  <= 40'(i_cfg.inner_radius) * 40'(i_cfg.inner_radius);
        r_rout2 <= 40'(i_cfg.outer_radius) * 40'(i_cfg.outer_radius);
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (en[1]) r_d[i]  <= 21'(pt[i]) - 21'(ctr[i]);
            if (en[2]) begin
                r_pa[i] <= 37'(vy[i]) * 37'(r_d[i]);
                r_pb[i] <= 37'(vx[i]) * 37'(r_d[i]);
            end
            if (en[4]) begin
                r_qa[i] <= 41'(r_a) * 41'(vy[i]);
                r_qb[i] <= 41'(r_b) * 41'(vx[i]);
            end
            if (en[5]) r_m[i] <= sm[i][41:14];
            if (en[6]) begin
                r_py[i] <= 44'(vy[i]) * 44'(r_m[i]);
                r_px[i] <= 44'(vx[i]) * 44'(r_m[i]);
                r_sq[i] <= 56'(r_m[i]) * 56'(r_m[i]);
            end
        end
        if (en[3]) begin
            r_a <= sa[38:14];
            r_b <= sb[38:14];
        end
        if (en[7]) begin
            r_y  <= 46'(r_py[0]) + 46'(r_py[1]) + 46'(r_py[2]);
            r_x  <= 46'(r_px[0]) + 46'(r_px[1]) + 46'(r_px[2]);
            r_r2 <= 57'($unsigned(r_sq[0])) + 57'($unsigned(r_sq[1]))
                  + 57'($unsigned(r_sq[2]));
        end
        if (en[8]) r_cord <= n_cord;
    end

    `include "angular_sector_bin_index_unit_macros.svh"

    // An accepted request always lands in the first stage.
    `ASBI_ASSERT(a_proj_take, i_valid && o_ready |=> r_v[1], "request lost at entry")

endmodule

`default_nettype wire

### src/asbi_cordic_cell.sv
// One CORDIC vectoring cell: a single rotation step and its register.
`default_nettype none

module asbi_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  asbi_pkg::t_cord     i_d,
    output logic                o_valid,
    input  wire                 i_ready,
    output asbi_pkg::t_cord     o_d
);

    logic            r_v;
    asbi_pkg::t_cord r_d;
    asbi_pkg::t_cord n_d;
    logic            en;

    assign en      = !r_v || i_ready;
    assign o_ready = en;
    assign o_valid = r_v;
    assign o_d     = r_d;

    // Rotate toward the real axis by the step's angle.
    always_comb begin
        n_d = i_d;
        if (i_d.im >= 0) begin
            n_d.re  = i_d.re + (i_d.im >>> STEP);
            n_d.im  = i_d.im - (i_d.re >>> STEP);
            n_d.acc = i_d.acc + asbi_pkg::ATAN_TURNS[STEP];
        end else begin
            n_d.re  = i_d.re - (i_d.im >>> STEP);
            n_d.im  = i_d.im + (i_d.re >>> STEP);
            n_d.acc = i_d.acc - asbi_pkg::ATAN_TURNS[STEP];
        end
    end

    // Valid bit of the cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
    end

    // Cell data.
    always_ff @(posedge i_clk) begin
        if (en) r_d <= n_d;
    end

    `include "angular_sector_bin_index_unit_macros.svh"

    // A stalled cell keeps its data.
    `ASBI_ASSERT(a_cell_hold, o_valid && !i_ready |=> o_valid && $stable(r_d), "cell data moved")

endmodule

`default_nettype wire

### src/asbi_bin.sv
// Back end: angle window test, bin scaling and the result register.
`default_nettype none

module asbi_bin #(
    parameter int MAX_BINS = 256
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  asbi_pkg::t_cfg      i_cfg,
    input  wire                 i_valid,
    output logic                o_ready,
    input  asbi_pkg::t_cord     i_cord,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic                o_in_bin,
    output logic [7:0]          o_bin_index
);

    localparam int NS = 3;

    logic [NS:1]   r_v;
    logic [NS+1:1] en;

    logic [15:0] ang;
    logic [15:0] start;
    logic [15:0] stop;
    logic        r_ok_a;
    logic [15:0] r_diff;
    logic        r_ok_b;
    logic [47:0] r_prod;
    logic        r_in_bin;
    logic [7:0]  r_idx;
    logic [31:0] cnt;
    logic [31:0] num;
    logic        n_in_bin;
    logic [31:0] n_bin;

    always_comb begin
        en[NS+1] = i_ready;
        for (int k = NS; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready     = en[1];
    assign o_valid     = r_v[NS];
    assign o_in_bin    = r_in_bin;
    assign o_bin_index = r_idx;

    // Final angle and the window bounds.
    always_comb begin
        ang   = i_cord.zero ? 16'd0 : i_cord.acc[31:16];
        start = i_cfg.angle_range[15:0];
        stop  = i_cfg.angle_range[31:16];
    end

    // Bin number with the count clamped and the top edge folded into the last bin.
    always_comb begin
        cnt = (32'(i_cfg.bin_count) > 32'(MAX_BINS)) ? 32'(MAX_BINS) : 32'(i_cfg.bin_count);
        num = r_prod[47:16];
        n_in_bin = r_ok_b && (cnt != '0) && (num <= cnt);
        n_bin = (num == cnt) ? (cnt - 32'd1) : num;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 1; k <= NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= (k == 1) ? i_valid : r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_ok_a <= i_cord.ok && (ang >= start) && (ang <= stop);
            r_diff <= ang - start;
        end
        if (en[2]) begin
            r_ok_b <= r_ok_a;
            r_prod <= 48'(r_diff) * 48'(i_cfg.bin_scale);
        end
        if (en[3]) begin
            r_in_bin <= n_in_bin;
            r_idx    <= n_in_bin ? n_bin[7:0] : 8'd0;
        end
    end

    `include "angular_sector_bin_index_unit_macros.svh"

    // No bin means a zero index.
    `ASBI_ASSERT(a_bin_zero, o_valid && !o_in_bin |-> o_bin_index == 8'd0, "index without bin")
    // Reset empties the result register.
    `ASBI_ASSERT_RST(a_bin_rst, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

`default_nettype wire

### src/angular_sector_bin_index_unit.sv
// Pipeline: 8 projection stages, 18 CORDIC cells and 3 bin stages from request accept to result.
// Throughput: one request per cycle; each stage holds only while its successor is stalled.
// The CORDIC cell chain performs one rotation step per cell.
// Reset (synchronous, active low) empties every stage and loads the register defaults.
// Top level: configuration registers and the projection, CORDIC and bin chain.
`default_nettype none

module angular_sector_bin_index_unit #(
    parameter int MAX_BINS = 256
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire [5:0]           paddr,
    input  wire [63:0]          pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire signed [19:0]   i_point_x,
    input  wire signed [19:0]   i_point_y,
    input  wire signed [19:0]   i_point_z,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic                o_in_bin,
    output logic [7:0]          o_bin_index
);

    localparam int NC = asbi_pkg::CORDIC_STEPS;

    asbi_pkg::t_cfg   r_cfg;
    asbi_pkg::t_reg_idx reg_idx;
    logic             wr;

    asbi_pkg::t_cord  w_cord [NC+1];
    logic             w_v [NC+1];
    logic             w_r [NC+1];

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite && pready;
    assign reg_idx = asbi_pkg::t_reg_idx'(paddr[5:3]);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.centre_point <= '0;
            r_cfg.ref_x_vector <= 48'd16384;
            r_cfg.ref_y_vector <= 48'd1073741824;
            r_cfg.inner_radius <= '0;
            r_cfg.outer_radius <= 20'hFFFFF;
            r_cfg.angle_range  <= 32'hFFFF_0000;
            r_cfg.bin_scale    <= 32'd65537;
            r_cfg.bin_count    <= 9'd1;
        end else if (wr) begin
            unique case (reg_idx)
                asbi_pkg::REG_CENTRE: r_cfg.centre_point <= pwdata[59:0];
                asbi_pkg::REG_REF_X:  r_cfg.ref_x_vector <= pwdata[47:0];
                asbi_pkg::REG_REF_Y:  r_cfg.ref_y_vector <= pwdata[47:0];
                asbi_pkg::REG_INNER:  r_cfg.inner_radius <= pwdata[19:0];
                asbi_pkg::REG_OUTER:  r_cfg.outer_radius <= pwdata[19:0];
                asbi_pkg::REG_ANGLE:  r_cfg.angle_range  <= pwdata[31:0];
                asbi_pkg::REG_SCALE:  r_cfg.bin_scale    <= pwdata[31:0];
                asbi_pkg::REG_COUNT:  r_cfg.bin_count    <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (reg_idx)
            asbi_pkg::REG_CENTRE: prdata = 64'(r_cfg.centre_point);
            asbi_pkg::REG_REF_X:  prdata = 64'(r_cfg.ref_x_vector);
            asbi_pkg::REG_REF_Y:  prdata = 64'(r_cfg.ref_y_vector);
            asbi_pkg::REG_INNER:  prdata = 64'(r_cfg.inner_radius);
            asbi_pkg::REG_OUTER:  prdata = 64'(r_cfg.outer_radius);
            asbi_pkg::REG_ANGLE:  prdata = 64'(r_cfg.angle_range);
            asbi_pkg::REG_SCALE:  prdata = 64'(r_cfg.bin_scale);
            asbi_pkg::REG_COUNT:  prdata = 64'(r_cfg.bin_count);
            default:              prdata = '0;
        endcase
    end

    // Projection front end.
    asbi_proj u_proj (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_point_z (i_point_z),
        .o_valid   (w_v[0]),
        .i_ready   (w_r[0]),
        .o_cord    (w_cord[0])
    );

    // Chain of CORDIC cells.
    for (genvar g = 0; g < NC; g++) begin : g_cell
        asbi_cordic_cell #(.STEP(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[g]),
            .o_ready (w_r[g]),
            .i_d     (w_cord[g]),
            .o_valid (w_v[g+1]),
            .i_ready (w_r[g+1]),
            .o_d     (w_cord[g+1])
        );
    end

    // Angle window, bin scaling and result register.
    asbi_bin #(.MAX_BINS(MAX_BINS)) u_bin (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (w_v[NC]),
        .o_ready     (w_r[NC]),
        .i_cord      (w_cord[NC]),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_in_bin    (o_in_bin),
        .o_bin_index (o_bin_index)
    );

endmodule

`default_nettype wire
